// ===== rtl/core/pwook_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pulse-width OOK frame sender: codes, register layout,
// reset values and the configuration struct. No dependencies.
package pwook_pkg;

  localparam int MSG_BITS_DEF = 12;
  localparam int TIME_W       = 16;
  localparam int REP_W        = 4;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] REG_SHORT_TIME   = 2'd0;
  localparam logic [1:0] REG_LONG_TIME    = 2'd1;
  localparam logic [1:0] REG_PAUSE_TIME   = 2'd2;
  localparam logic [1:0] REG_REPEAT_COUNT = 2'd3;

  localparam logic [TIME_W-1:0] SHORT_TIME_RST   = 16'd1000;
  localparam logic [TIME_W-1:0] LONG_TIME_RST    = 16'd2000;
  localparam logic [TIME_W-1:0] PAUSE_TIME_RST   = 16'd35000;
  localparam logic [REP_W-1:0]  REPEAT_COUNT_RST = 4'd4;

  typedef struct packed {
    logic [TIME_W-1:0] short_time;
    logic [TIME_W-1:0] long_time;
    logic [TIME_W-1:0] pause_time;
    logic [REP_W-1:0]  repeat_count;
  } cfg_t;

  function automatic logic [TIME_W-1:0] nz_time(input logic [TIME_W-1:0] v);
    return (v == '0) ? TIME_W'(1) : v;
  endfunction

  function automatic logic [REP_W-1:0] nz_rep(input logic [REP_W-1:0] v);
    return (v == '0) ? REP_W'(1) : v;
  endfunction

endpackage

// ===== rtl/core/pwook_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frame sender: command items in,
// status items out. Depends on pwook_pkg.
interface pwook_in_if #(
  parameter int MSG_BITS = pwook_pkg::MSG_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [MSG_BITS-1:0] message;

  modport source (output valid, output opcode, output message, input ready);
  modport sink   (input valid, input opcode, input message, output ready);
endinterface

interface pwook_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic accepted;
  logic done_res;

  modport source (output valid, output pin_level, output busy_res, output accepted,
                  output done_res, input ready);
  modport sink   (input valid, input pin_level, input busy_res, input accepted,
                  input done_res, output ready);
endinterface

// ===== rtl/core/pwook_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style register file for the frame sender timing and repeat count.
// Depends on pwook_pkg.
module pwook_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pwook_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pwook_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pwook_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output pwook_pkg::cfg_t                     cfg_o
);

  pwook_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        pwook_pkg::REG_SHORT_TIME:   cfg_d.short_time   = pwdata[pwook_pkg::TIME_W-1:0];
        pwook_pkg::REG_LONG_TIME:    cfg_d.long_time    = pwdata[pwook_pkg::TIME_W-1:0];
        pwook_pkg::REG_PAUSE_TIME:   cfg_d.pause_time   = pwdata[pwook_pkg::TIME_W-1:0];
        pwook_pkg::REG_REPEAT_COUNT: cfg_d.repeat_count = pwdata[pwook_pkg::REP_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pwook_pkg::REG_SHORT_TIME:   prdata = pwook_pkg::CFG_DATA_W'(cfg_q.short_time);
      pwook_pkg::REG_LONG_TIME:    prdata = pwook_pkg::CFG_DATA_W'(cfg_q.long_time);
      pwook_pkg::REG_PAUSE_TIME:   prdata = pwook_pkg::CFG_DATA_W'(cfg_q.pause_time);
      pwook_pkg::REG_REPEAT_COUNT: prdata = pwook_pkg::CFG_DATA_W'(cfg_q.repeat_count);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_time   <= pwook_pkg::SHORT_TIME_RST;
      cfg_q.long_time    <= pwook_pkg::LONG_TIME_RST;
      cfg_q.pause_time   <= pwook_pkg::PAUSE_TIME_RST;
      cfg_q.repeat_count <= pwook_pkg::REPEAT_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/pwook_engine.sv =====
`timescale 1ns / 1ps
// Waveform sequencer: frame state, timers and the registered status item.
// Depends on pwook_pkg and pwook_if.
module pwook_engine #(
  parameter int MSG_BITS = pwook_pkg::MSG_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pwook_pkg::cfg_t cfg_i,
  pwook_in_if.sink        in_ch,
  pwook_out_if.source     out_ch
);

  localparam int BitsW = $clog2(MSG_BITS + 1);
  localparam int TW    = pwook_pkg::TIME_W;
  localparam int RW    = pwook_pkg::REP_W;

  typedef enum logic [2:0] {
    PhIdle, PhSync, PhLow, PhHigh, PhPause
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [BitsW-1:0]    bits_q, bits_d, bits_dec;
  logic [RW-1:0]       frames_q, frames_d, frames_dec;
  logic [TW-1:0]       time_q, time_d, time_dec;
  logic [MSG_BITS-1:0] shift_q, shift_d, shifted;
  logic [MSG_BITS-1:0] saved_q, saved_d;
  logic                res_valid_q;
  logic                pin_q, busy_q, acc_q, done_q;
  logic                acc_d, done_d;
  logic                in_fire;

  assign in_ch.ready = !res_valid_q || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign time_dec   = (time_q != '0) ? time_q - TW'(1) : time_q;
  assign bits_dec   = (bits_q != '0) ? bits_q - BitsW'(1) : bits_q;
  assign frames_dec = (frames_q != '0) ? frames_q - RW'(1) : frames_q;
  assign shifted    = shift_q << 1;

  always_comb begin
    phase_d  = phase_q;
    bits_d   = bits_q;
    frames_d = frames_q;
    time_d   = time_q;
    shift_d  = shift_q;
    saved_d  = saved_q;
    acc_d    = 1'b0;
    done_d   = 1'b0;
    if (in_fire) begin
      if (in_ch.opcode == pwook_pkg::OP_START) begin
        if (phase_q == PhIdle) begin
          saved_d  = in_ch.message;
          shift_d  = in_ch.message;
          frames_d = pwook_pkg::nz_rep(cfg_i.repeat_count);
          bits_d   = '0;
          phase_d  = PhSync;
          time_d   = pwook_pkg::nz_time(cfg_i.short_time);
          acc_d    = 1'b1;
        end
      end else if (phase_q != PhIdle) begin
        time_d = time_dec;
        if (time_dec == '0) begin
          unique case (phase_q)
            PhSync: begin
              bits_d  = BitsW'(MSG_BITS);
              phase_d = PhLow;
              time_d  = pwook_pkg::nz_time(shift_q[MSG_BITS-1] ? cfg_i.short_time
                                                               : cfg_i.long_time);
            end
            PhLow: begin
              phase_d = PhHigh;
              time_d  = pwook_pkg::nz_time(shift_q[MSG_BITS-1] ? cfg_i.long_time
                                                               : cfg_i.short_time);
            end
            PhHigh: begin
              shift_d = shifted;
              bits_d  = bits_dec;
              if (bits_dec != '0) begin
                phase_d = PhLow;
                time_d  = pwook_pkg::nz_time(shifted[MSG_BITS-1] ? cfg_i.short_time
                                                                 : cfg_i.long_time);
              end else begin
                phase_d = PhPause;
                time_d  = pwook_pkg::nz_time(cfg_i.pause_time);
              end
            end
            PhPause: begin
              frames_d = frames_dec;
              if (frames_dec != '0) begin
                shift_d = saved_q;
                phase_d = PhSync;
                time_d  = pwook_pkg::nz_time(cfg_i.short_time);
              end else begin
                phase_d = PhIdle;
                time_d  = '0;
                done_d  = 1'b1;
              end
            end
            default: phase_d = PhIdle;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bits_q      <= '0;
      frames_q    <= '0;
      time_q      <= '0;
      shift_q     <= '0;
      saved_q     <= '0;
      res_valid_q <= 1'b0;
      pin_q       <= 1'b0;
      busy_q      <= 1'b0;
      acc_q       <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      bits_q   <= bits_d;
      frames_q <= frames_d;
      time_q   <= time_d;
      shift_q  <= shift_d;
      saved_q  <= saved_d;
      if (in_fire) begin
        res_valid_q <= 1'b1;
        pin_q       <= (phase_d == PhSync) || (phase_d == PhHigh);
        busy_q      <= (phase_d != PhIdle);
        acc_q       <= acc_d;
        done_q      <= done_d;
      end else if (out_ch.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = res_valid_q;
  assign out_ch.pin_level = pin_q;
  assign out_ch.busy_res  = busy_q;
  assign out_ch.accepted  = acc_q;
  assign out_ch.done_res  = done_q;

  a_acc_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && acc_q |-> pin_q && busy_q && (phase_q == PhSync))
    else $error("accepted start without sync level");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && done_q |-> !pin_q && !busy_q && (phase_q == PhIdle))
    else $error("done while still transmitting");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (frames_q == '0))
    else $error("frames pending while idle");

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BitsW'(MSG_BITS))
    else $error("bit counter out of range");

  a_busy_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhIdle) |-> (time_q != '0))
    else $error("timer expired without phase change");

endmodule

// ===== rtl/core/pulse_width_ook_frame_sender.sv =====
`timescale 1ns / 1ps
// Top level of the pulse-width OOK frame sender: register port and sequencer.
// Depends on pwook_pkg, pwook_if, pwook_cfg_regs and pwook_engine.
//
//   port     dir  kind          payload
//   in_i     in   valid/ready   opcode, message
//   out_o    out  valid/ready   pin_level, busy_res, accepted, done_res
//   APB      in   psel/penable  short_time, long_time, pause_time, repeat_count
//
// One item per cycle unless stalled; its status item comes next cycle from the
// result register. The sequencer state updates at the edge that takes the item.
// Reset clears state to idle with the pin low and loads the default timing.
// A stalled status item holds; a new item is taken when the result register
// is empty or drains in the same cycle.
module pulse_width_ook_frame_sender #(
  parameter int MSG_BITS = pwook_pkg::MSG_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pwook_in_if.sink                           in_i,
  pwook_out_if.source                        out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwook_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pwook_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pwook_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready
);

  pwook_pkg::cfg_t cfg;

  pwook_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwook_engine #(
    .MSG_BITS (MSG_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_i),
    .out_ch (out_o)
  );

endmodule

// ===== dv/tb_pulse_width_ook_frame_sender.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pulse_width_ook_frame_sender: drives command items and
// APB register writes, predicts every status item and compares it field by field.
// Depends on pwook_pkg, pwook_if and the frame sender RTL.
module tb_pulse_width_ook_frame_sender;

  localparam int MSG_W       = pwook_pkg::MSG_BITS_DEF;
  localparam int AW          = pwook_pkg::CFG_ADDR_W;
  localparam int DW          = pwook_pkg::CFG_DATA_W;
  localparam int TW          = pwook_pkg::TIME_W;
  localparam int RW          = pwook_pkg::REP_W;
  localparam int CLK_PERIOD  = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 120;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_SYNC, SEQ_LOW, SEQ_HIGH, SEQ_PAUSE
  } seq_phase_e;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
    logic done_res;
  } status_t;

  typedef struct packed {
    logic             drain;
    logic             typed;
    logic             opcode;
    logic [MSG_W-1:0] message;
    status_t          status;
  } stim_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  pwook_in_if #(.MSG_BITS(MSG_W)) cmd_if ();
  pwook_out_if                    status_if ();

  pulse_width_ook_frame_sender #(.MSG_BITS(MSG_W)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_if),
    .out_o   (status_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // sender model state
  pwook_pkg::cfg_t  timing;
  seq_phase_e       seq;
  logic [3:0]       bits_todo;
  logic [3:0]       frames_todo;
  logic [TW-1:0]    ticks_todo;
  logic [MSG_W-1:0] shift_bits;
  logic [MSG_W-1:0] held_msg;

  status_t status_q[$];
  int      err_cnt        = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  logic    hold_on        = 1'b0;
  event    hold_req;

  stim_row_t dir_rows [14] = '{
    '{1'b0, 1'b1, pwook_pkg::OP_TICK,  12'h000, 4'b0000},
    '{1'b0, 1'b1, pwook_pkg::OP_TICK,  12'hFFF, 4'b0000},
    '{1'b0, 1'b1, pwook_pkg::OP_START, 12'hFFF, 4'b1110},
    '{1'b0, 1'b1, pwook_pkg::OP_START, 12'h000, 4'b1100},
    '{1'b0, 1'b1, pwook_pkg::OP_TICK,  12'h000, 4'b0100},
    '{1'b0, 1'b1, pwook_pkg::OP_TICK,  12'hFFF, 4'b1100},
    '{1'b0, 1'b1, pwook_pkg::OP_START, 12'h5A5, 4'b1100},
    '{1'b0, 1'b0, pwook_pkg::OP_TICK,  12'h3C3, 4'b0000},
    '{1'b1, 1'b0, pwook_pkg::OP_TICK,  12'h000, 4'b0000},
    '{1'b0, 1'b1, pwook_pkg::OP_START, 12'h000, 4'b1110},
    '{1'b1, 1'b0, pwook_pkg::OP_TICK,  12'h000, 4'b0000},
    '{1'b0, 1'b0, pwook_pkg::OP_START, 12'hA5C, 4'b0000},
    '{1'b0, 1'b0, pwook_pkg::OP_TICK,  12'hFFF, 4'b0000},
    '{1'b1, 1'b0, pwook_pkg::OP_TICK,  12'h000, 4'b0000}
  };

  function automatic logic [TW-1:0] floor_one(input logic [TW-1:0] v);
    return (v == '0) ? TW'(1) : v;
  endfunction

  function automatic void load_bit_low();
    seq        = SEQ_LOW;
    ticks_todo = floor_one(shift_bits[MSG_W-1] ? timing.short_time : timing.long_time);
  endfunction

  function automatic void load_sync();
    shift_bits = held_msg;
    seq        = SEQ_SYNC;
    ticks_todo = floor_one(timing.short_time);
  endfunction

  // move to the next part of the frame; true when the final pause ends
  function automatic bit next_part();
    case (seq)
      SEQ_SYNC: begin
        bits_todo = 4'(MSG_W);
        load_bit_low();
      end
      SEQ_LOW: begin
        seq        = SEQ_HIGH;
        ticks_todo = floor_one(shift_bits[MSG_W-1] ? timing.long_time : timing.short_time);
      end
      SEQ_HIGH: begin
        shift_bits = shift_bits << 1;
        if (bits_todo != 0) bits_todo--;
        if (bits_todo != 0) begin
          load_bit_low();
        end else begin
          seq        = SEQ_PAUSE;
          ticks_todo = floor_one(timing.pause_time);
        end
      end
      SEQ_PAUSE: begin
        if (frames_todo != 0) frames_todo--;
        if (frames_todo != 0) begin
          load_sync();
        end else begin
          seq        = SEQ_IDLE;
          ticks_todo = '0;
          return 1'b1;
        end
      end
      default: seq = SEQ_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic status_t predict_status(input logic op, input logic [MSG_W-1:0] msg);
    status_t s;
    s = '0;
    if (op == pwook_pkg::OP_START) begin
      if (seq == SEQ_IDLE) begin
        held_msg    = msg;
        frames_todo = (timing.repeat_count == '0) ? 4'd1 : timing.repeat_count;
        bits_todo   = '0;
        load_sync();
        s.accepted = 1'b1;
      end
    end else if (seq != SEQ_IDLE) begin
      if (ticks_todo != 0) ticks_todo--;
      if (ticks_todo == 0) s.done_res = next_part();
    end
    s.pin_level = (seq == SEQ_SYNC) || (seq == SEQ_HIGH);
    s.busy_res  = (seq != SEQ_IDLE);
    return s;
  endfunction

  function automatic logic [DW-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      pwook_pkg::REG_SHORT_TIME:   return DW'(timing.short_time);
      pwook_pkg::REG_LONG_TIME:    return DW'(timing.long_time);
      pwook_pkg::REG_PAUSE_TIME:   return DW'(timing.pause_time);
      pwook_pkg::REG_REPEAT_COUNT: return DW'(timing.repeat_count);
      default:                     return '0;
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    err_cnt++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // long receiver hold-off, counted here while the sender keeps offering items
  initial begin
    forever begin
      @(hold_req);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    status_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  // sample on the falling edge ahead of the edge that takes the item
  always @(negedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && status_if.valid && status_if.ready) begin
      got = {status_if.pin_level, status_if.busy_res, status_if.accepted, status_if.done_res};
      if (status_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected status item, expected none, actual %b", $time, got);
      end else begin
        want = status_q.pop_front();
        if (got.pin_level !== want.pin_level)
          report_mismatch("pin_level", want.pin_level, got.pin_level);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", want.busy_res, got.busy_res);
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", want.accepted, got.accepted);
        if (got.done_res !== want.done_res)
          report_mismatch("done_res", want.done_res, got.done_res);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pwook_pkg::REG_SHORT_TIME:   timing.short_time   = val[TW-1:0];
      pwook_pkg::REG_LONG_TIME:    timing.long_time    = val[TW-1:0];
      pwook_pkg::REG_PAUSE_TIME:   timing.pause_time   = val[TW-1:0];
      pwook_pkg::REG_REPEAT_COUNT: timing.repeat_count = val[RW-1:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= AW'({i[1:0], 2'b00});
      @(posedge clk_i);
      penable <= 1'b1;
      @(negedge clk_i);
      while (!pready) @(negedge clk_i);
      if (prdata !== reg_value(i[1:0]))
        report_mismatch($sformatf("register %0d readback", i), reg_value(i[1:0]), prdata);
      @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic set_timing(input int s, input int l, input int p, input int r);
    reg_write(pwook_pkg::REG_SHORT_TIME, DW'(s));
    reg_write(pwook_pkg::REG_LONG_TIME, DW'(l));
    reg_write(pwook_pkg::REG_PAUSE_TIME, DW'(p));
    reg_write(pwook_pkg::REG_REPEAT_COUNT, DW'(r));
    check_regs();
  endtask

  task automatic send_cmd(input logic op, input logic [MSG_W-1:0] msg, input bit typed,
                          input status_t want);
    status_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.opcode  <= op;
    cmd_if.message <= msg;
    @(negedge clk_i);
    while (!cmd_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    s = predict_status(op, msg);
    status_q.push_back(typed ? want : s);
  endtask

  task automatic drain_to_idle();
    while (seq != SEQ_IDLE) send_cmd(pwook_pkg::OP_TICK, MSG_W'($urandom), 1'b0, '0);
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input bit with_hold);
    int   cnt;
    logic op;
    cnt = 0;
    while (cnt < n) begin
      if (seq == SEQ_IDLE)
        op = ($urandom_range(9) < 8) ? pwook_pkg::OP_START : pwook_pkg::OP_TICK;
      else
        op = ($urandom_range(99) < 3) ? pwook_pkg::OP_START : pwook_pkg::OP_TICK;
      // ticks while idle and starts while busy are noise
      if ((op == pwook_pkg::OP_START) == (seq == SEQ_IDLE)) cnt++;
      if (with_hold && cnt == n / 2) -> hold_req;
      send_cmd(op, MSG_W'($urandom), 1'b0, '0);
    end
    drain_to_idle();
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cmd_if.valid    = 1'b0;
    cmd_if.opcode   = pwook_pkg::OP_TICK;
    cmd_if.message  = '0;
    status_if.ready = 1'b0;
    timing          = '{pwook_pkg::SHORT_TIME_RST, pwook_pkg::LONG_TIME_RST,
                        pwook_pkg::PAUSE_TIME_RST, pwook_pkg::REPEAT_COUNT_RST};
    seq             = SEQ_IDLE;
    bits_todo       = '0;
    frames_todo     = '0;
    ticks_todo      = '0;
    shift_bits      = '0;
    held_msg        = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    set_timing(1, 2, 3, 2);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].drain) drain_to_idle();
      else send_cmd(dir_rows[i].opcode, dir_rows[i].message, dir_rows[i].typed,
                    dir_rows[i].status);
    end
    settle();

    // zero timing and repeat count fall back to one
    set_timing(0, 0, 0, 0);
    send_cmd(pwook_pkg::OP_START, MSG_W'($urandom), 1'b0, '0);
    drain_to_idle();
    settle();

    set_timing(1, 1, 1, 15);
    send_cmd(pwook_pkg::OP_START, 12'h6B1, 1'b0, '0);
    drain_to_idle();
    settle();

    set_timing(2, 3, 9, 1);
    send_cmd(pwook_pkg::OP_START, 12'h94E, 1'b0, '0);
    drain_to_idle();
    settle();

    set_timing(16'hFFFF, 16'hFFFF, 1, 1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      set_timing($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 8),
                 $urandom_range(1, 3));
      run_random(RAND_ITEMS, ph == 0);
    end

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
